// ===== sv/spectrum_bar_smoother_top_defines.svh =====
// Assertion macros for the spectrum bar smoother.
`ifndef SPECTRUM_BAR_SMOOTHER_TOP_DEFINES_SVH
`define SPECTRUM_BAR_SMOOTHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBS_ASSERT(lbl, clk, rst, prop, msg)
`define SBS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/sbs_pkg.sv =====
// Shared types, constants and arithmetic for the spectrum bar smoother.
package sbs_pkg;

   localparam int MAX_BARS = 64;
   localparam int BAR_W    = $clog2(MAX_BARS);

   localparam logic [19:0] RECIP_Q16  = 20'd728178;
   localparam logic [17:0] THRESH_Q16 = 18'd19660;
   localparam logic [17:0] OFFSET_Q16 = 18'd6554;
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [17:0] LEVEL_MAX  = 18'd262143;

   localparam logic [1:0] CSR_FFT_LOG2 = 2'd0;
   localparam logic [1:0] CSR_RISE     = 2'd1;
   localparam logic [1:0] CSR_FALL     = 2'd2;
   localparam logic [1:0] CSR_SPREAD   = 2'd3;

   typedef struct packed {
      logic [4:0]  fft_length_log2;
      logic [16:0] rise_gain;
      logic [16:0] fall_gain;
      logic [16:0] spread_gain;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic norm_en;
      logic blend_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // g*a + (1-g)*b, rounded, written as b + g*(a-b) to need one multiplier
   function automatic logic [17:0] sbs_blend(input logic [16:0] g_raw,
                                             input logic [17:0] a,
                                             input logic [17:0] b);
      logic [16:0]        g;
      logic signed [18:0] diff;
      logic signed [36:0] prod;
      logic signed [37:0] acc;
      g    = (g_raw > ONE_Q16) ? ONE_Q16 : g_raw;
      diff = $signed({1'b0, a}) - $signed({1'b0, b});
      prod = diff * $signed({1'b0, g});
      acc  = $signed({4'b0, b, 16'b0}) + 38'(prod) + 38'sd32768;
      return acc[33:16];
   endfunction

endpackage

// ===== sv/sbs_csr.sv =====
// Configuration register file of the spectrum bar smoother.
module sbs_csr import sbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FFT_LOG2: cfg_in.fft_length_log2 = csr_wdata[4:0];
            CSR_RISE:     cfg_in.rise_gain       = csr_wdata;
            CSR_FALL:     cfg_in.fall_gain       = csr_wdata;
            CSR_SPREAD:   cfg_in.spread_gain     = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fft_length_log2 <= 5'd11;
         cfg_ff.rise_gain       <= 17'd52429;
         cfg_ff.fall_gain       <= 17'd13107;
         cfg_ff.spread_gain     <= 17'd52429;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/sbs_ctrl.sv =====
// Sequencer of the spectrum bar smoother: accept, normalize, time blend, commit.
`include "spectrum_bar_smoother_top_defines.svh"
module sbs_ctrl import sbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_NORM   = 2'd1;
   localparam logic [1:0] S_BLEND  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_NORM;
            end
         end
         S_NORM: begin
            cmd.norm_en = 1'b1;
            state_in    = S_BLEND;
         end
         S_BLEND: begin
            cmd.blend_en = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SBS_ASSERT(a_accept_to_norm, clock, reset, cmd.accept |=> (state_ff == S_NORM), "accept not followed by normalize")
   `SBS_ASSERT(a_commit_free, clock, reset, cmd.commit |-> status.out_free, "commit into a full output register")
   `SBS_ASSERT_NR(a_reset_idle, clock, $past(reset) |-> (state_ff == S_IDLE), "not idle after reset")

endmodule

// ===== sv/sbs_dpath.sv =====
// Datapath of the spectrum bar smoother: scaling, compression, blends, history.
module sbs_dpath import sbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [BAR_W-1:0] BAR_LAST = BAR_W'(MAX_BARS - 1);

   // history memory and its valid bits
   logic [17:0]         hist_mem [MAX_BARS];
   logic [MAX_BARS-1:0] hist_valid_ff, hist_valid_in;
   logic [17:0]         prev_rd_ff;
   logic                prev_valid_ff;

   logic [BAR_W-1:0] bar_cnt_ff, bar_cnt_in;
   logic [BAR_W-1:0] bar_ff;
   logic             last_ff;
   logic [51:0]      prod_ff;
   logic [17:0]      val_ff;
   logic [17:0]      t_ff;
   logic [17:0]      neigh_ff, neigh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [17:0]      out_level_ff;
   logic [BAR_W-1:0] out_bar_ff;
   logic             out_last_ff;

   logic [51:0] prod_in;
   logic [5:0]  shift;
   logic [52:0] rsum;
   logic [52:0] v_sh;
   logic [52:0] v_cmp;
   logic [17:0] val_in;
   logic [17:0] prev;
   logic [16:0] g_time;
   logic [17:0] t_in;
   logic [17:0] s_in;

   assign prod_in = {20'b0, req_tdata} * {32'b0, RECIP_Q16};

   always_comb begin
      shift = 6'd16 + {1'b0, cfg.fft_length_log2};
      rsum  = {1'b0, prod_ff} + (53'd1 << (shift - 6'd1));
      v_sh  = rsum >> shift;
      v_cmp = (v_sh > 53'(THRESH_Q16)) ? ((v_sh >> 1) + 53'(OFFSET_Q16)) : v_sh;
      val_in = (v_cmp > 53'(LEVEL_MAX)) ? LEVEL_MAX : v_cmp[17:0];
   end

   always_comb begin
      prev   = prev_valid_ff ? prev_rd_ff : 18'd0;
      g_time = (val_ff < prev) ? cfg.fall_gain : cfg.rise_gain;
      t_in   = sbs_blend(g_time, val_ff, prev);
      s_in   = (bar_ff == '0) ? t_ff : sbs_blend(cfg.spread_gain, t_ff, neigh_ff);
   end

   always_comb begin
      status.out_free = !rsp_valid_ff || rsp_tready;

      bar_cnt_in    = bar_cnt_ff;
      neigh_in      = neigh_ff;
      hist_valid_in = hist_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.commit) begin
         bar_cnt_in             = (last_ff || bar_ff == BAR_LAST) ? '0 : bar_ff + BAR_W'(1);
         neigh_in               = s_in;
         hist_valid_in[bar_ff]  = 1'b1;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_cnt_ff    <= '0;
         neigh_ff      <= '0;
         hist_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bar_cnt_ff    <= bar_cnt_in;
         neigh_ff      <= neigh_in;
         hist_valid_ff <= hist_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prod_ff       <= prod_in;
         bar_ff        <= bar_cnt_ff;
         last_ff       <= req_tlast;
         prev_rd_ff    <= hist_mem[bar_cnt_ff];
         prev_valid_ff <= hist_valid_ff[bar_cnt_ff];
      end
      if (cmd.norm_en) begin
         val_ff <= val_in;
      end
      if (cmd.blend_en) begin
         t_ff <= t_in;
      end
      if (cmd.commit) begin
         hist_mem[bar_ff] <= s_in;
         out_level_ff     <= s_in;
         out_bar_ff       <= bar_ff;
         out_last_ff      <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'(out_bar_ff), out_level_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/spectrum_bar_smoother_top.sv =====
// Each bar is handled by the sequencer in order: accept with multiply, normalize, time blend,
// then cross-bar blend with history write; rsp_tvalid is registered at that commit step.
// A new bar is accepted only after the last one has committed.
// A result waiting on rsp_tready stalls the commit step, and with it the accept of the next bar.
// Reset (synchronous, active high) restores register defaults and clears the history
// valid bits, bar counter and neighbour level at once.
module spectrum_bar_smoother_top import sbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] magnitude
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] bar_level, [23:18] bar_number
   output logic        rsp_tlast,   // last_bar
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   sbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sbs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
